### sv/owtr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the 1-Wire temperature reader.
// No dependencies; owtr_csr, owtr_seq, the top and the testbench refer to it by scoped names.
package owtr_pkg;

   // ROM and function commands of the sensor
   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_SP  = 8'hBE;

   // Steps of a measurement sequence
   localparam logic [2:0] STEP_RESET_FIRST = 3'd0;
   localparam logic [2:0] STEP_RESET_CONV  = 3'd1;
   localparam logic [2:0] STEP_SKIP_CONV   = 3'd2;
   localparam logic [2:0] STEP_CONVERT     = 3'd3;
   localparam logic [2:0] STEP_CONV_WAIT   = 3'd4;
   localparam logic [2:0] STEP_RESET_READ  = 3'd5;
   localparam logic [2:0] STEP_SKIP_READ   = 3'd6;
   localparam logic [2:0] STEP_READ_CMD    = 3'd7;

   // Configuration register indexes
   localparam logic [2:0] CSR_RESET_LOW   = 3'd0;
   localparam logic [2:0] CSR_PRES_DELAY  = 3'd1;
   localparam logic [2:0] CSR_PRES_WINDOW = 3'd2;
   localparam logic [2:0] CSR_PRES_RECOV  = 3'd3;
   localparam logic [2:0] CSR_SLOT        = 3'd4;
   localparam logic [2:0] CSR_CONV_WAIT   = 3'd5;

   localparam int unsigned CONV_WAIT_BITS = 20;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_RST_WAIT,
      PH_POLL,
      PH_PRES_REC,
      PH_W_START,
      PH_W_DATA,
      PH_W_REC,
      PH_CONV,
      PH_R_START,
      PH_R_REL,
      PH_R_DATA
   } owtr_phase_type;

   typedef struct packed {
      logic [15:0] reset_low_ticks;
      logic [15:0] presence_delay_ticks;
      logic [7:0]  presence_window_ticks;
      logic [15:0] presence_recovery_ticks;
      logic [7:0]  slot_ticks;
      logic [19:0] convert_wait_ticks;
   } owtr_cfg_type;

   typedef struct packed {
      logic        line_drive_low;
      logic        busy_res;
      logic        done_res;
      logic        sensor_absent;
      logic        negative;
      logic [14:0] temp_tenths;
   } owtr_res_type;

endpackage

### sv/owtr_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the 1-Wire temperature reader: tick input,
// per-tick result and configuration write. No dependencies.
interface owtr_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic line_level;

   modport source (output valid, output start_req, output line_level, input ready);
   modport sink   (input valid, input start_req, input line_level, output ready);
endinterface

interface owtr_rsp_if;
   logic        valid;
   logic        ready;
   logic        line_drive_low;
   logic        busy_res;
   logic        done_res;
   logic        sensor_absent;
   logic        negative;
   logic [14:0] temp_tenths;

   modport source (output valid, output line_drive_low, output busy_res, output done_res,
                   output sensor_absent, output negative, output temp_tenths, input ready);
   modport sink   (input valid, input line_drive_low, input busy_res, input done_res,
                   input sensor_absent, input negative, input temp_tenths, output ready);
endinterface

interface owtr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [19:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/owtr_csr.sv
`timescale 1ns / 1ps
// Configuration registers of the 1-Wire temperature reader.
// Depends on owtr_pkg and owtr_csr_if.
module owtr_csr (
   input  logic                  clock,
   input  logic                  reset,
   owtr_csr_if.sink              csr_if,
   output owtr_pkg::owtr_cfg_type cfg
);

   owtr_pkg::owtr_cfg_type cfg_ff;

   assign csr_if.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks         <= 16'd500;
         cfg_ff.presence_delay_ticks    <= 16'd60;
         cfg_ff.presence_window_ticks   <= 8'd60;
         cfg_ff.presence_recovery_ticks <= 16'd420;
         cfg_ff.slot_ticks              <= 8'd60;
         cfg_ff.convert_wait_ticks      <= 20'd1000;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            owtr_pkg::CSR_RESET_LOW:   cfg_ff.reset_low_ticks <= csr_if.data[15:0];
            owtr_pkg::CSR_PRES_DELAY:  cfg_ff.presence_delay_ticks <= csr_if.data[15:0];
            owtr_pkg::CSR_PRES_WINDOW: cfg_ff.presence_window_ticks <= csr_if.data[7:0];
            owtr_pkg::CSR_PRES_RECOV:  cfg_ff.presence_recovery_ticks <= csr_if.data[15:0];
            owtr_pkg::CSR_SLOT:        cfg_ff.slot_ticks <= csr_if.data[7:0];
            owtr_pkg::CSR_CONV_WAIT:   cfg_ff.convert_wait_ticks <= csr_if.data;
            default: ;
         endcase
      end
   end

endmodule

### sv/owtr_in_reg.sv
`timescale 1ns / 1ps
// Input register of the 1-Wire temperature reader: holds one tick sample
// until the sequencer steps on it. Depends on owtr_req_if.
module owtr_in_reg (
   input  logic      clock,
   input  logic      reset,
   owtr_req_if.sink  req_if,
   input  logic      advance,
   output logic      item_valid,
   output logic      item_start,
   output logic      item_line
);

   logic valid_ff;
   logic start_ff;
   logic line_ff;

   assign req_if.ready = !valid_ff || advance;
   assign item_valid   = valid_ff;
   assign item_start   = start_ff;
   assign item_line    = line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         start_ff <= req_if.start_req;
         line_ff  <= req_if.line_level;
      end
   end

endmodule

### sv/owtr_temp.sv
`timescale 1ns / 1ps
// Scratchpad value to sign and rounded tenths of a degree.
// No dependencies.
module owtr_temp (
   input  logic [15:0] raw,
   output logic        negative,
   output logic [14:0] tenths
);

   logic [15:0] mag;
   logic [19:0] scaled;

   assign negative = raw[15];
   // 0x8000 negates to itself, which is the right magnitude
   assign mag      = raw[15] ? (~raw + 16'd1) : raw;
   // mag * 10 / 16, rounded half up
   assign scaled   = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + 20'd8;
   assign tenths   = scaled[18:4];

endmodule

### sv/owtr_seq.sv
`timescale 1ns / 1ps
// Sequencer of the 1-Wire temperature reader: bus timing state machine,
// stepped once per tick. Depends on owtr_pkg and owtr_temp.
module owtr_seq #(
   parameter int unsigned TICK_COUNTER_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   start,
   input  logic                   line,
   input  owtr_pkg::owtr_cfg_type cfg,
   output owtr_pkg::owtr_res_type res
);

   localparam int unsigned TW = TICK_COUNTER_BITS;
   localparam int unsigned LW = (TW > owtr_pkg::CONV_WAIT_BITS) ? TW : owtr_pkg::CONV_WAIT_BITS;
   localparam logic [LW-1:0] TMAX = LW'({TW{1'b1}});

   owtr_pkg::owtr_phase_type phase_ff, phase_in, phase_cur;
   logic [TW-1:0] tick_ff, tick_in, tick_cur, tick_inc;
   logic [7:0]    poll_ff, poll_in, poll_inc;
   logic [2:0]    bit_ff, bit_in, bit_cur;
   logic [2:0]    byte_ff, byte_in, byte_cur, byte_step;
   logic [7:0]    shift_ff, shift_in, shift_rd;
   logic [7:0]    low_ff, low_in;
   logic          neg_ff, neg_in;
   logic [14:0]   tenths_ff, tenths_in;

   logic [LW-1:0] limit_raw, limit;
   logic          timeout;
   logic          go_next;
   logic          neg_calc;
   logic [14:0]   tenths_calc;

   // A start in idle opens the first reset step on the same tick
   always_comb begin
      phase_cur = phase_ff;
      tick_cur  = tick_ff;
      bit_cur   = bit_ff;
      byte_cur  = byte_ff;
      if (phase_ff == owtr_pkg::PH_IDLE && start) begin
         phase_cur = owtr_pkg::PH_RST_LOW;
         tick_cur  = '0;
         bit_cur   = '0;
         byte_cur  = owtr_pkg::STEP_RESET_FIRST;
      end
   end

   always_comb begin
      unique case (phase_cur)
         owtr_pkg::PH_RST_LOW:  limit_raw = LW'(cfg.reset_low_ticks);
         owtr_pkg::PH_RST_WAIT: limit_raw = LW'(cfg.presence_delay_ticks);
         owtr_pkg::PH_PRES_REC: limit_raw = LW'(cfg.presence_recovery_ticks);
         owtr_pkg::PH_W_DATA:   limit_raw = LW'(cfg.slot_ticks);
         owtr_pkg::PH_CONV:     limit_raw = LW'(cfg.convert_wait_ticks);
         owtr_pkg::PH_R_DATA:   limit_raw = LW'(cfg.slot_ticks) + LW'(1);
         default:               limit_raw = '0;
      endcase
   end

   assign limit     = (limit_raw > TMAX) ? TMAX : limit_raw;
   assign tick_inc  = tick_cur + TW'(1);
   assign timeout   = LW'(tick_inc) >= limit;
   assign poll_inc  = poll_ff + 8'd1;
   assign byte_step = byte_cur + 3'd1;
   // sample the bus on the first data tick of a read slot, after the release tick
   assign shift_rd  = (tick_cur == '0) ? {line, shift_ff[7:1]} : shift_ff;

   owtr_temp u_temp (
      .raw      ({shift_rd, low_ff}),
      .negative (neg_calc),
      .tenths   (tenths_calc)
   );

   always_comb begin
      phase_in  = phase_cur;
      tick_in   = tick_cur;
      poll_in   = poll_ff;
      bit_in    = bit_cur;
      byte_in   = byte_cur;
      shift_in  = shift_ff;
      low_in    = low_ff;
      neg_in    = neg_ff;
      tenths_in = tenths_ff;
      go_next   = 1'b0;
      res.line_drive_low = 1'b0;
      res.busy_res       = phase_cur != owtr_pkg::PH_IDLE;
      res.done_res       = 1'b0;
      res.sensor_absent  = 1'b0;

      unique case (phase_cur)
         owtr_pkg::PH_IDLE: ;
         owtr_pkg::PH_RST_LOW: begin
            res.line_drive_low = 1'b1;
            tick_in = tick_inc;
            if (timeout) begin
               tick_in  = '0;
               phase_in = owtr_pkg::PH_RST_WAIT;
            end
         end
         owtr_pkg::PH_RST_WAIT: begin
            tick_in = tick_inc;
            if (timeout) begin
               poll_in  = '0;
               phase_in = owtr_pkg::PH_POLL;
            end
         end
         owtr_pkg::PH_POLL: begin
            if (!line) begin
               tick_in  = '0;
               phase_in = owtr_pkg::PH_PRES_REC;
            end else begin
               poll_in = poll_inc;
               if (poll_inc == cfg.presence_window_ticks) begin
                  // only the first reset gives up on a silent bus
                  if (byte_cur == owtr_pkg::STEP_RESET_FIRST) begin
                     res.done_res      = 1'b1;
                     res.sensor_absent = 1'b1;
                     phase_in          = owtr_pkg::PH_IDLE;
                  end else begin
                     go_next = 1'b1;
                  end
               end
            end
         end
         owtr_pkg::PH_PRES_REC: begin
            tick_in = tick_inc;
            go_next = timeout;
         end
         owtr_pkg::PH_W_START: begin
            res.line_drive_low = 1'b1;
            tick_in  = '0;
            phase_in = owtr_pkg::PH_W_DATA;
         end
         owtr_pkg::PH_W_DATA: begin
            res.line_drive_low = !shift_ff[bit_cur];
            tick_in = tick_inc;
            if (timeout) begin
               phase_in = owtr_pkg::PH_W_REC;
            end
         end
         owtr_pkg::PH_W_REC: begin
            if (bit_cur == 3'd7) begin
               go_next = 1'b1;
            end else begin
               bit_in   = bit_cur + 3'd1;
               phase_in = owtr_pkg::PH_W_START;
            end
         end
         owtr_pkg::PH_CONV: begin
            tick_in = tick_inc;
            go_next = timeout;
         end
         owtr_pkg::PH_R_START: begin
            res.line_drive_low = 1'b1;
            phase_in = owtr_pkg::PH_R_REL;
         end
         owtr_pkg::PH_R_REL: begin
            tick_in  = '0;
            phase_in = owtr_pkg::PH_R_DATA;
         end
         owtr_pkg::PH_R_DATA: begin
            shift_in = shift_rd;
            tick_in  = tick_inc;
            if (timeout) begin
               if (bit_cur != 3'd7) begin
                  bit_in   = bit_cur + 3'd1;
                  phase_in = owtr_pkg::PH_R_START;
               end else if (byte_cur == 3'd0) begin
                  low_in   = shift_rd;
                  shift_in = '0;
                  bit_in   = '0;
                  byte_in  = 3'd1;
                  phase_in = owtr_pkg::PH_R_START;
               end else begin
                  neg_in       = neg_calc;
                  tenths_in    = tenths_calc;
                  res.done_res = 1'b1;
                  phase_in     = owtr_pkg::PH_IDLE;
               end
            end
         end
         default: phase_in = owtr_pkg::PH_IDLE;
      endcase

      if (go_next) begin
         tick_in = '0;
         bit_in  = '0;
         if (byte_cur == owtr_pkg::STEP_READ_CMD) begin
            byte_in  = '0;
            shift_in = '0;
            phase_in = owtr_pkg::PH_R_START;
         end else begin
            byte_in = byte_step;
            unique case (byte_step)
               owtr_pkg::STEP_SKIP_CONV, owtr_pkg::STEP_SKIP_READ: begin
                  shift_in = owtr_pkg::CMD_SKIP_ROM;
                  phase_in = owtr_pkg::PH_W_START;
               end
               owtr_pkg::STEP_CONVERT: begin
                  shift_in = owtr_pkg::CMD_CONVERT;
                  phase_in = owtr_pkg::PH_W_START;
               end
               owtr_pkg::STEP_CONV_WAIT: phase_in = owtr_pkg::PH_CONV;
               owtr_pkg::STEP_READ_CMD: begin
                  shift_in = owtr_pkg::CMD_READ_SP;
                  phase_in = owtr_pkg::PH_W_START;
               end
               default: phase_in = owtr_pkg::PH_RST_LOW;
            endcase
         end
      end

      res.negative    = neg_in;
      res.temp_tenths = tenths_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= owtr_pkg::PH_IDLE;
         tick_ff   <= '0;
         poll_ff   <= '0;
         bit_ff    <= '0;
         byte_ff   <= '0;
         shift_ff  <= '0;
         low_ff    <= '0;
         neg_ff    <= 1'b0;
         tenths_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         poll_ff   <= poll_in;
         bit_ff    <= bit_in;
         byte_ff   <= byte_in;
         shift_ff  <= shift_in;
         low_ff    <= low_in;
         neg_ff    <= neg_in;
         tenths_ff <= tenths_in;
      end
   end

endmodule

### sv/onewire_temperature_reader_top.sv
`timescale 1ns / 1ps
// Top level of the 1-Wire temperature reader.
// Depends on owtr_pkg, the owtr interfaces, owtr_csr, owtr_in_reg and owtr_seq.

// Each input transfer is one microsecond tick carrying the sampled bus level and a
// start request; each tick yields exactly one result transfer with the bus drive,
// busy, done, absent flags and the last reading. A tick is taken every cycle while
// results drain; it passes an input register and the sequencer step into a result
// register, which holds its result until it transfers out. Throughput is one tick
// per cycle, set by the single state machine step per tick; a stalled result holds
// the input register, and req ready drops once that register is full. Write
// configuration only while no sequence runs and no ticks are in flight.
module onewire_temperature_reader_top #(
   parameter int unsigned TICK_COUNTER_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   owtr_req_if.sink    req_if,
   owtr_rsp_if.source  rsp_if,
   owtr_csr_if.sink    csr_if
);

   owtr_pkg::owtr_cfg_type cfg;
   owtr_pkg::owtr_res_type res;
   owtr_pkg::owtr_res_type rsp_data_ff;
   logic                   rsp_valid_ff;
   logic                   advance;
   logic                   item_valid;
   logic                   item_start;
   logic                   item_line;
   logic                   step;

   assign advance = !rsp_valid_ff || rsp_if.ready;
   assign step    = item_valid && advance;

   owtr_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   owtr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (advance),
      .item_valid (item_valid),
      .item_start (item_start),
      .item_line  (item_line)
   );

   owtr_seq #(
      .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .start (item_start),
      .line  (item_line),
      .cfg   (cfg),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the result until the transfer completes
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.line_drive_low = rsp_data_ff.line_drive_low;
   assign rsp_if.busy_res       = rsp_data_ff.busy_res;
   assign rsp_if.done_res       = rsp_data_ff.done_res;
   assign rsp_if.sensor_absent  = rsp_data_ff.sensor_absent;
   assign rsp_if.negative       = rsp_data_ff.negative;
   assign rsp_if.temp_tenths    = rsp_data_ff.temp_tenths;

   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(item_valid))
      else $error("result appeared without a stored tick");

   a_drive_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.line_drive_low |-> rsp_data_ff.busy_res)
      else $error("bus driven low outside a sequence");

   a_absent_with_done: assert property (@(posedge clock) disable iff (reset)
      step && res.sensor_absent |=> rsp_data_ff.done_res && rsp_valid_ff)
      else $error("absent flag without done");

endmodule

### test/tb_onewire_temperature_reader_top.sv
`timescale 1ns / 1ps
// Testbench of the 1-Wire temperature reader: drives microsecond ticks with a
// behavioral sensor, predicts every per-tick result and checks it field by field.
// Depends on owtr_pkg, the owtr interfaces and onewire_temperature_reader_top.
module tb_onewire_temperature_reader_top;

   localparam int unsigned TICK_BITS      = 20;
   localparam int unsigned TICK_MAX       = (1 << TICK_BITS) - 1;
   localparam int unsigned RANDOM_TICKS   = 350;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 10;
   // indexes past the register file, writes there must change nothing
   localparam logic [2:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [2:0] CSR_UNUSED_HI = 3'd7;

   localparam logic [15:0] SPECIAL_RAW [8] = '{16'h0000, 16'h0008, 16'h07D0, 16'h7FFF,
                                              16'h8000, 16'hFFFF, 16'hFC90, 16'h0001};

   logic clock;
   logic reset;

   owtr_req_if req_ch ();
   owtr_rsp_if rsp_ch ();
   owtr_csr_if csr_ch ();

   onewire_temperature_reader_top #(
      .TICK_COUNTER_BITS(TICK_BITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_if(csr_ch)
   );

   // predicted reader state
   owtr_pkg::owtr_cfg_type   timing;
   owtr_pkg::owtr_phase_type ph;
   logic [19:0]              tick_cnt;
   logic [7:0]               polls;
   logic [2:0]               bit_no;
   logic [2:0]               step_no;
   logic [7:0]               shreg;
   logic [7:0]               low_byte_q;
   logic                     neg_q;
   logic [14:0]              tenths_q;

   owtr_pkg::owtr_res_type pending_results [$];

   // behavioral sensor plan
   logic [2:0]  plan_present;
   int unsigned plan_lag;
   logic [15:0] plan_raw;
   int unsigned noise_pct;

   bit          idle_on;
   int unsigned items_sent;
   int unsigned errors;
   int unsigned quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit wait_expired(input int unsigned limit);
      int unsigned lim;
      lim = (limit > TICK_MAX) ? TICK_MAX : limit;
      tick_cnt = tick_cnt + 1'b1;
      return 32'(tick_cnt) >= lim;
   endfunction

   function automatic void enter_step(input logic [2:0] s);
      step_no  = s;
      tick_cnt = '0;
      bit_no   = '0;
      case (s)
         owtr_pkg::STEP_RESET_FIRST, owtr_pkg::STEP_RESET_CONV,
         owtr_pkg::STEP_RESET_READ: ph = owtr_pkg::PH_RST_LOW;
         owtr_pkg::STEP_SKIP_CONV, owtr_pkg::STEP_SKIP_READ: begin
            shreg = owtr_pkg::CMD_SKIP_ROM;
            ph    = owtr_pkg::PH_W_START;
         end
         owtr_pkg::STEP_CONVERT: begin
            shreg = owtr_pkg::CMD_CONVERT;
            ph    = owtr_pkg::PH_W_START;
         end
         owtr_pkg::STEP_CONV_WAIT: ph = owtr_pkg::PH_CONV;
         default: begin
            shreg = owtr_pkg::CMD_READ_SP;
            ph    = owtr_pkg::PH_W_START;
         end
      endcase
   endfunction

   function automatic void advance_step();
      if (step_no == owtr_pkg::STEP_READ_CMD) begin
         // step number becomes the byte number of the scratchpad read
         step_no  = '0;
         bit_no   = '0;
         shreg    = '0;
         tick_cnt = '0;
         ph       = owtr_pkg::PH_R_START;
      end else begin
         enter_step(step_no + 3'd1);
      end
   endfunction

   function automatic owtr_pkg::owtr_res_type reader_step(input logic start,
                                                          input logic line);
      owtr_pkg::owtr_res_type r;
      int unsigned            raw;
      int unsigned            mag;
      r = '0;
      if (ph == owtr_pkg::PH_IDLE && start) enter_step(owtr_pkg::STEP_RESET_FIRST);
      r.busy_res = (ph != owtr_pkg::PH_IDLE);
      case (ph)
         owtr_pkg::PH_RST_LOW: begin
            r.line_drive_low = 1'b1;
            if (wait_expired(32'(timing.reset_low_ticks))) begin
               tick_cnt = '0;
               ph       = owtr_pkg::PH_RST_WAIT;
            end
         end
         owtr_pkg::PH_RST_WAIT: begin
            if (wait_expired(32'(timing.presence_delay_ticks))) begin
               polls = '0;
               ph    = owtr_pkg::PH_POLL;
            end
         end
         owtr_pkg::PH_POLL: begin
            if (!line) begin
               tick_cnt = '0;
               ph       = owtr_pkg::PH_PRES_REC;
            end else begin
               polls = polls + 8'd1;
               if (polls == timing.presence_window_ticks) begin
                  // only the first reset may give up; later ones carry on
                  if (step_no == owtr_pkg::STEP_RESET_FIRST) begin
                     r.done_res      = 1'b1;
                     r.sensor_absent = 1'b1;
                     ph              = owtr_pkg::PH_IDLE;
                  end else begin
                     advance_step();
                  end
               end
            end
         end
         owtr_pkg::PH_PRES_REC: begin
            if (wait_expired(32'(timing.presence_recovery_ticks))) advance_step();
         end
         owtr_pkg::PH_W_START: begin
            r.line_drive_low = 1'b1;
            tick_cnt         = '0;
            ph               = owtr_pkg::PH_W_DATA;
         end
         owtr_pkg::PH_W_DATA: begin
            r.line_drive_low = ~shreg[bit_no];
            if (wait_expired(32'(timing.slot_ticks))) ph = owtr_pkg::PH_W_REC;
         end
         owtr_pkg::PH_W_REC: begin
            if (bit_no == 3'd7) begin
               advance_step();
            end else begin
               bit_no = bit_no + 3'd1;
               ph     = owtr_pkg::PH_W_START;
            end
         end
         owtr_pkg::PH_CONV: begin
            if (wait_expired(32'(timing.convert_wait_ticks))) advance_step();
         end
         owtr_pkg::PH_R_START: begin
            r.line_drive_low = 1'b1;
            ph               = owtr_pkg::PH_R_REL;
         end
         owtr_pkg::PH_R_REL: begin
            tick_cnt = '0;
            ph       = owtr_pkg::PH_R_DATA;
         end
         owtr_pkg::PH_R_DATA: begin
            if (tick_cnt == '0) shreg = {line, shreg[7:1]};
            if (wait_expired(32'(timing.slot_ticks) + 1)) begin
               if (bit_no != 3'd7) begin
                  bit_no = bit_no + 3'd1;
                  ph     = owtr_pkg::PH_R_START;
               end else if (step_no == 3'd0) begin
                  low_byte_q = shreg;
                  shreg      = '0;
                  bit_no     = '0;
                  step_no    = 3'd1;
                  ph         = owtr_pkg::PH_R_START;
               end else begin
                  raw   = {16'd0, shreg, low_byte_q};
                  neg_q = raw[15];
                  mag   = neg_q ? (32'h10000 - raw) : raw;
                  tenths_q = 15'((mag * 10 + 8) >> 4);
                  r.done_res = 1'b1;
                  ph         = owtr_pkg::PH_IDLE;
               end
            end
         end
         default: ph = owtr_pkg::PH_IDLE;
      endcase
      r.negative    = neg_q;
      r.temp_tenths = tenths_q;
      return r;
   endfunction

   function automatic void store_setting(input logic [2:0] idx, input logic [19:0] val);
      case (idx)
         owtr_pkg::CSR_RESET_LOW:   timing.reset_low_ticks         = val[15:0];
         owtr_pkg::CSR_PRES_DELAY:  timing.presence_delay_ticks    = val[15:0];
         owtr_pkg::CSR_PRES_WINDOW: timing.presence_window_ticks   = val[7:0];
         owtr_pkg::CSR_PRES_RECOV:  timing.presence_recovery_ticks = val[15:0];
         owtr_pkg::CSR_SLOT:        timing.slot_ticks              = val[7:0];
         owtr_pkg::CSR_CONV_WAIT:   timing.convert_wait_ticks      = val;
         default: ;
      endcase
   endfunction

   // bus level the sensor would show on the next tick
   function automatic logic pick_line();
      int unsigned idx;
      if ($urandom_range(0, 99) < noise_pct) return 1'($urandom_range(0, 1));
      case (ph)
         owtr_pkg::PH_POLL: begin
            idx = (step_no == owtr_pkg::STEP_RESET_FIRST) ? 0 :
                  (step_no == owtr_pkg::STEP_RESET_CONV) ? 1 : 2;
            return !(plan_present[idx] && 32'(polls) >= plan_lag);
         end
         owtr_pkg::PH_R_DATA: begin
            if (tick_cnt == '0) return plan_raw[{step_no[0], bit_no}];
            return 1'($urandom_range(0, 1));
         end
         default: return 1'($urandom_range(0, 1));
      endcase
   endfunction

   task automatic send_tick(input logic start, input logic line);
      int gap;
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.start_req  <= start;
      req_ch.line_level <= line;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_results.push_back(reader_step(start, line));
      items_sent++;
   endtask

   // hold ticks until every predicted result has been seen
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [19:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      store_setting(idx, val);
   endtask

   task automatic program_timing(input int unsigned rl, input int unsigned pd,
                                 input int unsigned pw, input int unsigned pr,
                                 input int unsigned sl, input int unsigned cw);
      csr_write(owtr_pkg::CSR_RESET_LOW, 20'(rl));
      csr_write(owtr_pkg::CSR_PRES_DELAY, 20'(pd));
      csr_write(owtr_pkg::CSR_PRES_WINDOW, 20'(pw));
      csr_write(owtr_pkg::CSR_PRES_RECOV, 20'(pr));
      csr_write(owtr_pkg::CSR_SLOT, 20'(sl));
      csr_write(owtr_pkg::CSR_CONV_WAIT, 20'(cw));
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // one measurement: idle lead-in, start, then ticks until the sequence ends
   task automatic run_measurement(input logic [15:0] raw, input logic [2:0] present,
                                  input int unsigned lag, input int unsigned lead,
                                  input int pause_at);
      int n;
      plan_raw     = raw;
      plan_present = present;
      plan_lag     = lag;
      repeat (lead) send_tick(1'b0, pick_line());
      send_tick(1'b1, pick_line());
      n = 0;
      while (ph != owtr_pkg::PH_IDLE) begin
         n++;
         if (n == pause_at) drain_results();
         send_tick(1'($urandom_range(0, 1)), pick_line());
      end
   endtask

   task automatic test_reset_values();
      noise_pct = 0;
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      // silent bus under the power-up timing, no idling to keep it short
      idle_on = 1'b0;
      run_measurement(16'h0191, 3'b000, 0, 2, -1);
      idle_on = 1'b1;
   endtask

   task automatic test_absent_and_masking();
      drain_results();
      // upper data bits beyond each register must be dropped
      csr_write(owtr_pkg::CSR_RESET_LOW, 20'hA0001);
      csr_write(owtr_pkg::CSR_PRES_DELAY, 20'h30000);
      csr_write(owtr_pkg::CSR_PRES_WINDOW, 20'hFFF01);
      csr_write(owtr_pkg::CSR_PRES_RECOV, 20'h50000);
      csr_write(owtr_pkg::CSR_SLOT, 20'hF0F01);
      csr_write(owtr_pkg::CSR_CONV_WAIT, 20'h00000);
      csr_write(CSR_UNUSED_LO, 20'($urandom));
      csr_write(CSR_UNUSED_HI, 20'($urandom));
      csr_ch.valid <= 1'b0;
      @(posedge clock);
      run_measurement(16'h0000, 3'b000, 0, 2, -1);
      run_measurement(16'h0000, 3'b000, 0, 0, -1);
      drain_results();
      program_timing(2, 2, 2, 1, 1, 0);
      run_measurement(16'h0000, 3'b000, 0, 1, -1);
      // presence lands on the last poll the window allows
      run_measurement(SPECIAL_RAW[4], 3'b111, 1, 0, -1);
   endtask

   task automatic test_window_extremes();
      drain_results();
      // a zero window wraps the poll counter and allows a full 256 polls
      program_timing(1, 0, 0, 0, 1, 0);
      run_measurement(16'h0000, 3'b000, 0, 0, -1);
   endtask

   task automatic test_random_reads();
      int unsigned first;
      int unsigned seq;
      logic [15:0] raw;
      logic [2:0]  present;
      int          pause_at;
      first = items_sent;
      seq   = 0;
      while (items_sent - first < RANDOM_TICKS) begin
         if (seq == 0 || $urandom_range(0, 1) == 0) begin
            drain_results();
            program_timing($urandom_range(1, 3), $urandom_range(0, 3), $urandom_range(1, 5),
                           $urandom_range(0, 3), $urandom_range(1, 4), $urandom_range(0, 5));
         end
         raw = (seq < 8) ? SPECIAL_RAW[seq] : 16'($urandom);
         present[0] = ($urandom_range(0, 9) != 0);
         present[1] = ($urandom_range(0, 6) != 0);
         present[2] = ($urandom_range(0, 6) != 0);
         noise_pct  = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(5, 15);
         idle_on    = ($urandom_range(0, 4) != 0);
         pause_at   = (seq == 0) ? 20 : ($urandom_range(0, 3) == 0) ? $urandom_range(1, 150) : -1;
         run_measurement(raw, present, $urandom_range(0, 3), $urandom_range(0, 4), pause_at);
         seq++;
      end
      noise_pct = 0;
      idle_on   = 1'b1;
   endtask

   task automatic test_late_absence();
      drain_results();
      // later resets without presence move on with no recovery wait
      program_timing(1, 0, 3, 9, 1, 0);
      run_measurement(16'($urandom), 3'b001, 0, 0, -1);
   endtask

   initial begin
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.start_req     <= 1'b0;
      req_ch.line_level    <= 1'b1;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= owtr_pkg::CSR_RESET_LOW;
      csr_ch.data          <= '0;
      timing.reset_low_ticks         = 16'd500;
      timing.presence_delay_ticks    = 16'd60;
      timing.presence_window_ticks   = 8'd60;
      timing.presence_recovery_ticks = 16'd420;
      timing.slot_ticks              = 8'd60;
      timing.convert_wait_ticks      = 20'd1000;
      ph         = owtr_pkg::PH_IDLE;
      tick_cnt   = '0;
      polls      = '0;
      bit_no     = '0;
      step_no    = '0;
      shreg      = '0;
      low_byte_q = '0;
      neg_q      = 1'b0;
      tenths_q   = '0;
      idle_on    = 1'b1;
      noise_pct  = 0;
      items_sent = 0;
      errors     = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_absent_and_masking();
      test_window_extremes();
      test_late_absence();
      test_random_reads();
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         errors++;
         $error("%0d predicted results never arrived", pending_results.size());
      end
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : result_monitor
      owtr_pkg::owtr_res_type want;
      int                     stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_on ? $urandom_range(0, 11) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         if (pending_results.size() == 0) begin
            errors++;
            $error("result transfer with no tick pending");
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.line_drive_low !== want.line_drive_low) begin
               errors++;
               $error("line_drive_low: expected %0d, got %0d",
                      want.line_drive_low, rsp_ch.line_drive_low);
            end
            if (rsp_ch.busy_res !== want.busy_res) begin
               errors++;
               $error("busy_res: expected %0d, got %0d", want.busy_res, rsp_ch.busy_res);
            end
            if (rsp_ch.done_res !== want.done_res) begin
               errors++;
               $error("done_res: expected %0d, got %0d", want.done_res, rsp_ch.done_res);
            end
            if (rsp_ch.sensor_absent !== want.sensor_absent) begin
               errors++;
               $error("sensor_absent: expected %0d, got %0d",
                      want.sensor_absent, rsp_ch.sensor_absent);
            end
            if (rsp_ch.negative !== want.negative) begin
               errors++;
               $error("negative: expected %0d, got %0d", want.negative, rsp_ch.negative);
            end
            if (rsp_ch.temp_tenths !== want.temp_tenths) begin
               errors++;
               $error("temp_tenths: expected %0d, got %0d",
                      want.temp_tenths, rsp_ch.temp_tenths);
            end
         end
      end
   end

   // end the run when no transfer of any kind happens for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

endmodule

### files.f
sv/owtr_pkg.sv
sv/owtr_if.sv
sv/owtr_csr.sv
sv/owtr_in_reg.sv
sv/owtr_temp.sv
sv/owtr_seq.sv
sv/onewire_temperature_reader_top.sv
test/tb_onewire_temperature_reader_top.sv
